@@ hdl/bpsk_frame_serializer_assert.svh @@
// ----------------------------------------------------------------------------
// bpsk frame serializer assertion macros
// concurrent checks clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef BPSK_FRAME_SERIALIZER_ASSERT_SVH
`define BPSK_FRAME_SERIALIZER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BFS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// shared types and constants of the bpsk frame serializer
// ----------------------------------------------------------------------------
package bfs_pkg;

   // request kinds carried in req_tuser
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_AMPLITUDE = 2'd0;
   localparam logic [1:0] CSR_PREAMBLE  = 2'd1;
   localparam logic [1:0] CSR_SYNC      = 2'd2;
   localparam logic [1:0] CSR_SPS       = 2'd3;

   // register reset values
   localparam logic [14:0] AMPLITUDE_RST = 15'd15000;
   localparam logic [15:0] PREAMBLE_RST  = 16'hAAAA;
   localparam logic [15:0] SYNC_RST      = 16'hEB90;
   localparam logic [4:0]  SPS_RST       = 5'd5;

   // payload byte value before the host writes it
   localparam logic [7:0]  FILL_BYTE     = 8'h55;

   // per-tick decode carried from the sequencer to the output stage
   typedef struct packed {
      logic       hdr_bit;   // bit value when sending preamble or sync
      logic       payload;   // bit comes from the payload store
      logic [2:0] shift;     // bit number inside the payload byte
      logic       last;      // last sample of the packet
   } tick_info_type;

endpackage

@@ hdl/bfs_store.sv @@
// ----------------------------------------------------------------------------
// bfs_store
// payload byte memory with registered read and per-entry written flags
// ----------------------------------------------------------------------------
module bfs_store #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [5:0] wr_index,
   input  logic [7:0] wr_byte,
   input  logic       rd_en,
   input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] rd_addr,
   output logic [7:0] rd_byte
);
   import bfs_pkg::*;

   localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int IW = 10;

   logic [7:0]               mem [PAYLOAD_BYTES];
   logic [PAYLOAD_BYTES-1:0] written_ff;
   logic [PAYLOAD_BYTES-1:0] written_in;
   logic [7:0]               rd_data_ff;
   logic                     rd_written_ff;
   logic                     wr_hit;
   logic [AW-1:0]            wr_addr;

   // indexes at or above the store depth are dropped
   assign wr_hit  = wr_en && (IW'(wr_index) < IW'(PAYLOAD_BYTES));
   assign wr_addr = AW'(wr_index);

   always_comb begin
      written_in = written_ff;
      if (wr_hit) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[wr_addr] <= wr_byte;
      end
      if (rd_en) begin
         rd_data_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_byte = rd_written_ff ? rd_data_ff : FILL_BYTE;

endmodule

@@ hdl/bfs_seq.sv @@
// ----------------------------------------------------------------------------
// bfs_seq
// bit and sample counters, per-tick decode register
// ----------------------------------------------------------------------------
module bfs_seq #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  logic [15:0]           preamble_word,
   input  logic [15:0]           sync_pattern,
   input  logic [4:0]            ticks_per_bit,
   output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] rd_addr,
   output bfs_pkg::tick_info_type info
);
   import bfs_pkg::*;

   localparam int AW          = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int PACKET_BITS = (4 + PAYLOAD_BYTES) * 8;
   localparam int BPW         = $clog2(PACKET_BITS);
   localparam int BYW         = BPW - 3;

   logic [BPW-1:0] bit_pos_ff;
   logic [BPW-1:0] bit_pos_in;
   logic [3:0]     phase_ff;
   logic [3:0]     phase_in;
   tick_info_type  info_ff;
   tick_info_type  info_in;
   logic [4:0]     sym_len;
   logic [4:0]     phase_inc;
   logic           bit_done;
   logic           pkt_done;
   logic [BYW-1:0] byte_no;

   // symbol length clamped to 1..16
   always_comb begin
      if (ticks_per_bit == 5'd0) begin
         sym_len = 5'd1;
      end else if (ticks_per_bit > 5'd16) begin
         sym_len = 5'd16;
      end else begin
         sym_len = ticks_per_bit;
      end
   end

   assign phase_inc = {1'b0, phase_ff} + 5'd1;
   assign bit_done  = (phase_inc >= sym_len);
   assign pkt_done  = bit_done && (bit_pos_ff == BPW'(PACKET_BITS - 1));
   assign byte_no   = bit_pos_ff[BPW-1:3];

   always_comb begin
      phase_in   = phase_ff;
      bit_pos_in = bit_pos_ff;
      if (tick_en) begin
         if (bit_done) begin
            phase_in = 4'd0;
            if (pkt_done) begin
               bit_pos_in = '0;
            end else begin
               bit_pos_in = bit_pos_ff + BPW'(1);
            end
         end else begin
            phase_in = phase_inc[3:0];
         end
      end
   end

   always_comb begin
      info_in.payload = (byte_no >= BYW'(4));
      info_in.shift   = 3'd7 - bit_pos_ff[2:0];
      info_in.last    = pkt_done;
      if (byte_no < BYW'(2)) begin
         info_in.hdr_bit = preamble_word[4'd15 - bit_pos_ff[3:0]];
      end else begin
         info_in.hdr_bit = sync_pattern[4'd15 - bit_pos_ff[3:0]];
      end
   end

   assign rd_addr = AW'(byte_no - BYW'(4));

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff <= '0;
         phase_ff   <= '0;
      end else begin
         bit_pos_ff <= bit_pos_in;
         phase_ff   <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en) begin
         info_ff <= info_in;
      end
   end

   assign info = info_ff;

endmodule

@@ hdl/bfs_out.sv @@
// ----------------------------------------------------------------------------
// bfs_out
// level mapping, decode stage control and result register
// ----------------------------------------------------------------------------
module bfs_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_en,
   input  bfs_pkg::tick_info_type info,
   input  logic [7:0]            rd_byte,
   input  logic [14:0]           amplitude,
   output logic                  stage_busy,
   output logic                  stage_free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [15:0]           out_level,
   output logic                  out_bit,
   output logic                  out_last
);
   import bfs_pkg::*;

   logic        stage_valid_ff;
   logic        stage_valid_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [15:0] level_ff;
   logic        bit_ff;
   logic        last_ff;
   logic        move;
   logic        tx_bit;
   logic [15:0] level_in;

   assign move       = stage_valid_ff && (!out_valid_ff || out_ready);
   assign stage_free = !stage_valid_ff || move;

   assign tx_bit   = info.payload ? rd_byte[info.shift] : info.hdr_bit;
   assign level_in = tx_bit ? {1'b0, amplitude} : (16'd0 - {1'b0, amplitude});

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (tick_en) begin
         stage_valid_in = 1'b1;
      end else if (move) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         level_ff <= level_in;
         bit_ff   <= tx_bit;
         last_ff  <= info.last;
      end
   end

   assign stage_busy = stage_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_level  = level_ff;
   assign out_bit    = bit_ff;
   assign out_last   = last_ff;

endmodule

@@ hdl/bpsk_frame_serializer.sv @@
// ----------------------------------------------------------------------------
// bpsk_frame_serializer
// bpsk packet modulator: preamble, sync word and host-written payload
// ----------------------------------------------------------------------------
// Each tick transfer on req yields one sample transfer on rsp; a payload
// write transfer yields none. Packets run back to back: 16-bit preamble,
// 16-bit sync word, then PAYLOAD_BYTES payload bytes, all msb first, each
// bit held for the configured number of ticks per bit (clamped to 1..16) at
// +amplitude for a one and -amplitude for a zero. The block takes one
// transfer every clock cycle while the decode stage has room; a tick's decode
// and payload read are registered together, then its sample in the result
// register. With rsp stalled, one more tick still enters the decode stage.
// Payload bytes read as 0x55 until written; a write reaches the air the next
// time that byte is sent, including the rest of the byte now in flight. Write
// indexes at or above PAYLOAD_BYTES are ignored. Configuration writes are
// always accepted and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "bpsk_frame_serializer_assert.svh"

module bpsk_frame_serializer #(
   parameter int PAYLOAD_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] byte_index, [13:6] byte_value, rest zero
   input  logic        req_tuser,   // req_type: 0 sample tick, 1 payload byte write
   // sample channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] sample_level, [16] bit_value, rest zero
   output logic        rsp_tlast,   // packet_end
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bfs_pkg::*;

   localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   // configuration registers
   logic [14:0]   amplitude_ff;
   logic [15:0]   preamble_ff;
   logic [15:0]   sync_ff;
   logic [4:0]    sps_ff;

   logic          req_xfer;
   logic          tick_en;
   logic          wr_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_byte;
   tick_info_type info;
   logic          stage_busy;
   logic          stage_free;
   logic [15:0]   out_level;
   logic          out_bit;

   // config writes go straight into their registers, so the port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= AMPLITUDE_RST;
         preamble_ff  <= PREAMBLE_RST;
         sync_ff      <= SYNC_RST;
         sps_ff       <= SPS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_AMPLITUDE: amplitude_ff <= csr_data[14:0];
            CSR_PREAMBLE:  preamble_ff  <= csr_data;
            CSR_SYNC:      sync_ff      <= csr_data;
            CSR_SPS:       sps_ff       <= csr_data[4:0];
            default:       ;
         endcase
      end
   end

   // a tick needs room in the decode stage; the stage frees as soon as the
   // result register can take its content
   assign req_tready = stage_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign tick_en    = req_xfer && (req_tuser == REQ_TICK);
   assign wr_en      = req_xfer && (req_tuser == REQ_WRITE);

   // counters and header bit decode, one step per tick
   bfs_seq #(
      .PAYLOAD_BYTES      (PAYLOAD_BYTES)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .tick_en            (tick_en),
      .preamble_word      (preamble_ff),
      .sync_pattern       (sync_ff),
      .ticks_per_bit      (sps_ff),
      .rd_addr            (rd_addr),
      .info               (info)
   );

   // payload memory, read alongside the decode register
   bfs_store #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (wr_en),
      .wr_index      (req_tdata[5:0]),
      .wr_byte       (req_tdata[13:6]),
      .rd_en         (tick_en),
      .rd_addr       (rd_addr),
      .rd_byte       (rd_byte)
   );

   // level mapping and result register
   bfs_out u_out (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .info       (info),
      .rd_byte    (rd_byte),
      .amplitude  (amplitude_ff),
      .stage_busy (stage_busy),
      .stage_free (stage_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_level  (out_level),
      .out_bit    (out_bit),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, out_bit, out_level};

   // an accepted tick always occupies the decode stage next cycle
   `BFS_ASSERT_NEXT(a_tick_enters_stage, tick_en, stage_busy, "tick lost at decode stage")
   // backpressure only when both stages hold samples and rsp is stalled
   `BFS_ASSERT_SAME(a_stall_cause, !req_tready, stage_busy && rsp_tvalid && !rsp_tready, "req stalled without cause")
   // a stalled decode stage keeps its content
   `BFS_ASSERT_NEXT(a_stage_hold, stage_busy && rsp_tvalid && !rsp_tready, stage_busy && $stable(info), "decode stage changed while stalled")

endmodule
